// ===== rtl/linear_probe_key_table_core_assert.svh =====
// ---------------------------------------------------------------------------
// linear_probe_key_table_core assertion macros
// Shorthand for clocked implication checks, disabled while active-low reset is low.
// ---------------------------------------------------------------------------
`ifndef LINEAR_PROBE_KEY_TABLE_CORE_ASSERT_SVH
`define LINEAR_PROBE_KEY_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define LPKT_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lpkt check failed");

// next-cycle implication
`define LPKT_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lpkt check failed");

`endif

// ===== rtl/lpkt_pkg.sv =====
// ---------------------------------------------------------------------------
// lpkt_pkg
// Shared types, codes and constants of the linear probe key table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpkt_pkg;

  localparam int TABLE_SLOTS_DEF   = 1024;
  localparam int MAX_KEY_WORDS_DEF = 4;
  localparam int VALUE_BITS_DEF    = 24;

  localparam int IN_WORDS   = 4;
  localparam int WORD_W     = 32;
  localparam int OPCODE_W   = 2;
  localparam int STATUS_W   = 3;
  localparam int SLOT_IDX_W = 10;
  localparam int SLOTS_CFG_W = 11;
  localparam int WORDS_CFG_W = 3;
  localparam int HASH_CFG_W  = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_IDX_W   = 2;

  localparam logic [SLOTS_CFG_W-1:0] SLOTS_RST = 11'd1024;
  localparam logic [WORDS_CFG_W-1:0] WORDS_RST = 3'd4;

  localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;
  localparam logic [31:0] GOLD_MUL   = 32'h9E3779B9;
  localparam logic [31:0] FMIX_C1    = 32'h85EBCA6B;
  localparam logic [31:0] FMIX_C2    = 32'hC2B2AE35;
  localparam logic [31:0] MUR_C1     = 32'hCC9E2D51;
  localparam logic [31:0] MUR_C2     = 32'h1B873593;
  localparam logic [31:0] MUR_ADD    = 32'hE6546B64;
  localparam logic [31:0] MUR_SEED   = 32'h9747B28C;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOTS = 2'd0,
    CFG_WORDS = 2'd1,
    CFG_HASH  = 2'd2
  } cfg_idx_t;

  typedef enum logic [HASH_CFG_W-1:0] {
    HK_FNV    = 2'd0,
    HK_MIX    = 2'd1,
    HK_MURMUR = 2'd2
  } hash_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_CLEARED   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_DECODE,
    S_HASH,
    S_MOD,
    S_READ,
    S_CHECK,
    S_POST
  } ctrl_state_t;

  typedef enum logic [3:0] {
    H_IDLE,
    H_FNV,
    H_MIX_MUL,
    H_FM_A,
    H_FM_B,
    H_FM_C,
    H_MUR_A,
    H_MUR_B,
    H_MUR_C,
    H_MUR_LEN,
    H_DONE
  } hash_ph_t;

  typedef struct packed {
    logic    capture;
    logic    hash_go;
    logic    mod_go;
    logic    probe_rd;
    logic    probe_adv;
    logic    ins_wr;
    logic    sweep;
    logic    res_load;
    status_t res_code;
  } dp_cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                hash_done;
    logic                mod_done;
    logic                sweep_last;
    logic                slot_valid;
    logic                key_eq;
    logic                last_try;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/lpkt_if.sv =====
// ---------------------------------------------------------------------------
// lpkt_in_if / lpkt_out_if
// Valid/ready channels for table operations and their results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lpkt_in_if import lpkt_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [OPCODE_W-1:0]      opcode;
  logic signed [WORD_W-1:0] key_word0;
  logic signed [WORD_W-1:0] key_word1;
  logic signed [WORD_W-1:0] key_word2;
  logic signed [WORD_W-1:0] key_word3;
  logic [VALUE_BITS-1:0]    entry_value;

  modport source (output valid, opcode, key_word0, key_word1, key_word2, key_word3,
                  entry_value, input ready);
  modport sink   (input valid, opcode, key_word0, key_word1, key_word2, key_word3,
                  entry_value, output ready);
endinterface

interface lpkt_out_if import lpkt_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic [VALUE_BITS-1:0] found_value;

  modport source (output valid, status, slot_index, found_value, input ready);
  modport sink   (input valid, status, slot_index, found_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/lpkt_hash.sv =====
// ---------------------------------------------------------------------------
// lpkt_hash
// Multi-cycle key hash with one shared 32x32 multiplier.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpkt_hash import lpkt_pkg::*; #(
  parameter int MAX_KEY_WORDS = MAX_KEY_WORDS_DEF,
  localparam int NWW = $clog2(MAX_KEY_WORDS + 1),
  localparam int KIW = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [HASH_CFG_W-1:0]           kind,
  input  logic [NWW-1:0]                  nw,
  input  logic [MAX_KEY_WORDS*WORD_W-1:0] key,
  output logic                            done,
  output logic [31:0]                     h
);

  hash_ph_t    ph_r, ph_nxt;
  logic [31:0] h_r, h_nxt;
  logic [31:0] t_r, t_nxt;
  logic [NWW-1:0] w_r, w_nxt;

  logic [31:0] kw [MAX_KEY_WORDS];
  logic [31:0] k, mul_a, mul_b, prod, mx;
  logic [NWW-1:0] w_inc;
  logic        w_last;

  always_comb begin
    for (int i = 0; i < MAX_KEY_WORDS; i++) begin
      kw[i] = key[i*WORD_W +: WORD_W];
    end
  end

  assign k      = kw[w_r[KIW-1:0]];
  assign w_inc  = w_r + 1'b1;
  assign w_last = (w_inc == nw);
  assign prod   = mul_a * mul_b;
  assign mx     = {h_r[18:0] ^ t_r[18:0], h_r[31:19] ^ t_r[31:19]};

  // phase sequencing
  always_comb begin
    ph_nxt = ph_r;
    unique case (ph_r)
      H_IDLE: begin
        if (start) begin
          priority if (kind == HK_FNV) ph_nxt = H_FNV;
          else if (kind == HK_MIX)     ph_nxt = H_MIX_MUL;
          else                         ph_nxt = H_MUR_A;
        end
      end
      H_FNV:     ph_nxt = w_last ? H_DONE : H_FNV;
      H_MIX_MUL: ph_nxt = H_FM_A;
      H_FM_A:    ph_nxt = H_FM_B;
      H_FM_B:    ph_nxt = H_FM_C;
      H_FM_C:    ph_nxt = (kind == HK_MIX && w_r != nw) ? H_MIX_MUL : H_DONE;
      H_MUR_A:   ph_nxt = H_MUR_B;
      H_MUR_B:   ph_nxt = H_MUR_C;
      H_MUR_C:   ph_nxt = w_last ? H_MUR_LEN : H_MUR_A;
      H_MUR_LEN: ph_nxt = H_FM_A;
      H_DONE:    ph_nxt = H_IDLE;
      default:   ph_nxt = H_IDLE;
    endcase
  end

  // datapath per phase
  always_comb begin
    h_nxt = h_r;
    t_nxt = t_r;
    w_nxt = w_r;
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (ph_r)
      H_IDLE: begin
        if (start) begin
          w_nxt = '0;
          priority if (kind == HK_FNV) h_nxt = FNV_BASIS;
          else if (kind == HK_MIX)     h_nxt = 32'd0;
          else                         h_nxt = MUR_SEED;
        end
      end
      H_FNV: begin
        mul_a = h_r ^ k;
        mul_b = FNV_PRIME;
        h_nxt = prod;
        w_nxt = w_inc;
      end
      H_MIX_MUL: begin
        mul_a = k;
        mul_b = GOLD_MUL;
        h_nxt = h_r + prod;
        w_nxt = w_inc;
      end
      H_FM_A: begin
        mul_a = h_r ^ (h_r >> 16);
        mul_b = FMIX_C1;
        h_nxt = prod;
      end
      H_FM_B: begin
        mul_a = h_r ^ (h_r >> 13);
        mul_b = FMIX_C2;
        h_nxt = prod;
      end
      H_FM_C:  h_nxt = h_r ^ (h_r >> 16);
      H_MUR_A: begin
        mul_a = k;
        mul_b = MUR_C1;
        t_nxt = prod;
      end
      H_MUR_B: begin
        mul_a = {t_r[16:0], t_r[31:17]};
        mul_b = MUR_C2;
        t_nxt = prod;
      end
      H_MUR_C: begin
        // x*5 + constant as shift-add
        h_nxt = (mx << 2) + mx + MUR_ADD;
        w_nxt = w_inc;
      end
      H_MUR_LEN: h_nxt = h_r ^ (32'(nw) << 2);
      H_DONE:    h_nxt = h_r;
      default:   h_nxt = h_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= H_IDLE;
    end else begin
      ph_r <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
    t_r <= t_nxt;
    w_r <= w_nxt;
  end

  assign done = (ph_r == H_DONE);
  assign h    = h_r;

endmodule

`default_nettype wire

// ===== rtl/lpkt_dp.sv =====
// ---------------------------------------------------------------------------
// lpkt_dp
// Datapath: config registers, hash, modulo reduction, slot store, results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpkt_dp import lpkt_pkg::*; #(
  parameter int TABLE_SLOTS   = TABLE_SLOTS_DEF,
  parameter int MAX_KEY_WORDS = MAX_KEY_WORDS_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [OPCODE_W-1:0]    in_opcode,
  input  logic [WORD_W-1:0]      in_word [IN_WORDS],
  input  logic [VALUE_BITS-1:0]  in_value,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  output logic [STATUS_W-1:0]    out_status,
  output logic [SLOT_IDX_W-1:0]  out_slot,
  output logic [VALUE_BITS-1:0]  out_value
);

  localparam int AW   = $clog2(TABLE_SLOTS);
  localparam int SW   = $clog2(TABLE_SLOTS + 1);
  localparam int NWW  = $clog2(MAX_KEY_WORDS + 1);
  localparam int KW   = MAX_KEY_WORDS * WORD_W;
  localparam int EW   = 1 + VALUE_BITS + KW;

  // configuration
  logic [SLOTS_CFG_W-1:0] slots_cfg_r;
  logic [WORDS_CFG_W-1:0] words_cfg_r;
  logic [HASH_CFG_W-1:0]  hash_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_cfg_r <= SLOTS_RST;
      words_cfg_r <= WORDS_RST;
      hash_cfg_r  <= HK_FNV;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SLOTS: slots_cfg_r <= cfg_data[SLOTS_CFG_W-1:0];
        CFG_WORDS: words_cfg_r <= cfg_data[WORDS_CFG_W-1:0];
        CFG_HASH:  hash_cfg_r  <= cfg_data[HASH_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  logic [31:0]    slots_ext, words_ext;
  logic [SW-1:0]  n_eff;
  logic [NWW-1:0] nw_eff;

  assign slots_ext = 32'(slots_cfg_r);
  assign words_ext = 32'(words_cfg_r);
  assign n_eff  = (slots_ext == 32'd0) ? SW'(1) :
                  (slots_ext > 32'(TABLE_SLOTS)) ? SW'(TABLE_SLOTS) : SW'(slots_ext);
  assign nw_eff = (words_ext == 32'd0) ? NWW'(1) :
                  (words_ext > 32'(MAX_KEY_WORDS)) ? NWW'(MAX_KEY_WORDS) : NWW'(words_ext);

  // captured transaction
  logic [OPCODE_W-1:0]   op_r;
  logic [KW-1:0]         key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r;

  always_comb begin
    for (int i = 0; i < MAX_KEY_WORDS; i++) begin
      key_nxt[i*WORD_W +: WORD_W] = (i < IN_WORDS) ? in_word[i % IN_WORDS] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_opcode;
      key_r <= key_nxt;
      val_r <= in_value;
    end
  end

  // hash unit
  logic        hash_done;
  logic [31:0] key_hash;

  lpkt_hash #(
    .MAX_KEY_WORDS(MAX_KEY_WORDS)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.hash_go),
    .kind  (hash_cfg_r),
    .nw    (nw_eff),
    .key   (key_r),
    .done  (hash_done),
    .h     (key_hash)
  );

  // restoring remainder, one hash bit per cycle
  logic          mod_busy_r, mod_done_r;
  logic [4:0]    mod_bit_r;
  logic [SW-1:0] rem_r;
  logic [SW:0]   rem_sh;
  logic [SW-1:0] rem_new;

  assign rem_sh  = {rem_r, key_hash[mod_bit_r]};
  assign rem_new = (rem_sh >= {1'b0, n_eff}) ? SW'(rem_sh - {1'b0, n_eff}) : SW'(rem_sh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_busy_r <= 1'b0;
      mod_done_r <= 1'b0;
    end else begin
      mod_done_r <= mod_busy_r && (mod_bit_r == 5'd0);
      if (cmd.mod_go) begin
        mod_busy_r <= 1'b1;
      end else if (mod_busy_r && mod_bit_r == 5'd0) begin
        mod_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_go) begin
      rem_r     <= '0;
      mod_bit_r <= 5'd31;
    end else if (mod_busy_r) begin
      rem_r     <= rem_new;
      mod_bit_r <= mod_bit_r - 5'd1;
    end
  end

  // probe position
  logic [AW-1:0] slot_r;
  logic [SW-1:0] tries_r;
  logic [SW-1:0] slot_inc;

  assign slot_inc = SW'(slot_r) + SW'(1);

  always_ff @(posedge clk) begin
    if (mod_busy_r && mod_bit_r == 5'd0) begin
      slot_r  <= rem_new[AW-1:0];
      tries_r <= '0;
    end else if (cmd.probe_adv) begin
      slot_r  <= (slot_inc == n_eff) ? '0 : slot_inc[AW-1:0];
      tries_r <= tries_r + SW'(1);
    end
  end

  // slot store and clearing sweep
  logic [EW-1:0] mem [TABLE_SLOTS];
  logic [EW-1:0] rdata_r;
  logic [AW-1:0] sweep_r;
  logic          sweep_last;

  assign sweep_last = (sweep_r == AW'(TABLE_SLOTS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep) begin
      sweep_r <= sweep_last ? '0 : sweep_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      mem[sweep_r] <= '0;
    end else if (cmd.ins_wr) begin
      mem[slot_r] <= {1'b1, val_r, key_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_rd) begin
      rdata_r <= mem[slot_r];
    end
  end

  logic                  rd_valid;
  logic [VALUE_BITS-1:0] rd_value;
  logic [KW-1:0]         rd_key;
  logic                  key_eq;

  assign rd_valid = rdata_r[EW-1];
  assign rd_value = rdata_r[KW +: VALUE_BITS];
  assign rd_key   = rdata_r[KW-1:0];

  always_comb begin
    key_eq = 1'b1;
    for (int i = 0; i < MAX_KEY_WORDS; i++) begin
      if (i < int'(nw_eff) && rd_key[i*WORD_W +: WORD_W] != key_r[i*WORD_W +: WORD_W]) begin
        key_eq = 1'b0;
      end
    end
  end

  // result register
  logic [STATUS_W-1:0]   out_status_r;
  logic [SLOT_IDX_W-1:0] out_slot_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic                  has_slot, has_value;

  assign has_slot  = (cmd.res_code == ST_INSERTED) || (cmd.res_code == ST_PRESENT) ||
                     (cmd.res_code == ST_FOUND);
  assign has_value = (cmd.res_code == ST_PRESENT) || (cmd.res_code == ST_FOUND);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status_r <= cmd.res_code;
      out_slot_r   <= has_slot ? SLOT_IDX_W'(slot_r) : '0;
      out_value_r  <= has_value ? rd_value : '0;
    end
  end

  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_value  = out_value_r;

  assign sts.op         = op_r;
  assign sts.hash_done  = hash_done;
  assign sts.mod_done   = mod_done_r;
  assign sts.sweep_last = sweep_last;
  assign sts.slot_valid = rd_valid;
  assign sts.key_eq     = key_eq;
  assign sts.last_try   = ({1'b0, tries_r} + (SW+1)'(1)) == {1'b0, n_eff};

endmodule

`default_nettype wire

// ===== rtl/lpkt_ctrl.sv =====
// ---------------------------------------------------------------------------
// lpkt_ctrl
// Operation sequencer: sweep, hash, reduce, probe, post result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "linear_probe_key_table_core_assert.svh"

module lpkt_ctrl import lpkt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  ctrl_state_t state_r, state_nxt;
  status_t     res_r, res_nxt;
  logic        resp_clear_r, resp_clear_nxt;
  logic        out_valid_r;
  logic        out_free;
  logic        is_ins;

  assign out_free = !out_valid_r || out_ready;
  assign is_ins   = (sts.op == OP_INSERT);

  // next state
  always_comb begin
    state_nxt      = state_r;
    res_nxt        = res_r;
    resp_clear_nxt = resp_clear_r;
    unique case (state_r)
      S_SWEEP: begin
        if (sts.sweep_last) begin
          state_nxt      = resp_clear_r ? S_POST : S_IDLE;
          res_nxt        = ST_CLEARED;
          resp_clear_nxt = 1'b0;
        end
      end
      S_IDLE: if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        priority if (sts.op == OP_INSERT || sts.op == OP_SEARCH) begin
          state_nxt = S_HASH;
        end else if (sts.op == OP_CLEAR) begin
          state_nxt      = S_SWEEP;
          resp_clear_nxt = 1'b1;
        end else begin
          state_nxt = S_POST;
          res_nxt   = ST_NOT_FOUND;
        end
      end
      S_HASH:  if (sts.hash_done) state_nxt = S_MOD;
      S_MOD:   if (sts.mod_done) state_nxt = S_READ;
      S_READ:  state_nxt = S_CHECK;
      S_CHECK: begin
        priority if (!sts.slot_valid) begin
          state_nxt = S_POST;
          res_nxt   = is_ins ? ST_INSERTED : ST_NOT_FOUND;
        end else if (sts.key_eq) begin
          state_nxt = S_POST;
          res_nxt   = is_ins ? ST_PRESENT : ST_FOUND;
        end else if (sts.last_try) begin
          state_nxt = S_POST;
          res_nxt   = is_ins ? ST_FULL : ST_NOT_FOUND;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_POST:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd           = '0;
    cmd.res_code  = res_r;
    cmd.capture   = (state_r == S_IDLE) && in_valid;
    cmd.hash_go   = (state_r == S_DECODE) && (sts.op == OP_INSERT || sts.op == OP_SEARCH);
    cmd.mod_go    = (state_r == S_HASH) && sts.hash_done;
    cmd.probe_rd  = (state_r == S_READ);
    cmd.probe_adv = (state_r == S_CHECK) && sts.slot_valid && !sts.key_eq && !sts.last_try;
    cmd.ins_wr    = (state_r == S_CHECK) && !sts.slot_valid && is_ins;
    cmd.sweep     = (state_r == S_SWEEP);
    cmd.res_load  = (state_r == S_POST) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      res_r        <= ST_NOT_FOUND;
      resp_clear_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      res_r        <= res_nxt;
      resp_clear_r <= resp_clear_nxt;
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `LPKT_ASSERT_NOW(a_load_free, clk, rst_n, cmd.res_load, !out_valid_r || out_ready)
  `LPKT_ASSERT_NOW(a_hash_state, clk, rst_n, sts.hash_done, state_r == S_HASH)
  `LPKT_ASSERT_NOW(a_ins_empty, clk, rst_n, cmd.ins_wr, !sts.slot_valid && is_ins)
  `LPKT_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire

// ===== rtl/linear_probe_key_table_core.sv =====
// ---------------------------------------------------------------------------
// linear_probe_key_table_core
// Open-addressing hash table with linear probing over multi-word keys.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// One transaction at a time. Insert/search: capture and decode, the
// hash (FNV-1a, mix or Murmur3, at most one 32x32 multiply per cycle),
// bit-serial modulo against the slot count, then a registered store read
// and a compare per probed slot, then the result is posted. Clear sweeps
// every physical slot, one per cycle, then posts its result. After reset
// the same sweep runs with in_txn.ready low; config writes are taken
// throughout. A finished result sits in the output register, so the next
// transaction is taken while it waits.

module linear_probe_key_table_core import lpkt_pkg::*; #(
  parameter int TABLE_SLOTS   = TABLE_SLOTS_DEF,
  parameter int MAX_KEY_WORDS = MAX_KEY_WORDS_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lpkt_in_if.sink               in_txn,
  lpkt_out_if.source            out_txn,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [WORD_W-1:0] in_word [IN_WORDS];

  // key words enter as raw bit patterns
  assign in_word[0] = in_txn.key_word0;
  assign in_word[1] = in_txn.key_word1;
  assign in_word[2] = in_txn.key_word2;
  assign in_word[3] = in_txn.key_word3;

  // sequencer
  lpkt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_txn.valid),
    .in_ready  (in_txn.ready),
    .out_valid (out_txn.valid),
    .out_ready (out_txn.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // hash, modulo, slot store, result register
  lpkt_dp #(
    .TABLE_SLOTS   (TABLE_SLOTS),
    .MAX_KEY_WORDS (MAX_KEY_WORDS),
    .VALUE_BITS    (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_opcode  (in_txn.opcode),
    .in_word    (in_word),
    .in_value   (in_txn.entry_value),
    .cmd        (cmd),
    .sts        (sts),
    .out_status (out_txn.status),
    .out_slot   (out_txn.slot_index),
    .out_value  (out_txn.found_value)
  );

endmodule

`default_nettype wire
